// File: src/dsac_pkg.sv
`timescale 1ns / 1ps

package dsac_pkg;

  // Field widths fixed by the interface.
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int TIME_W   = 11;
  localparam int WAIT_W   = 12;

  // Time constants, in minutes.
  localparam int HOUR_MINUTES = 60;
  localparam int DAY_MINUTES  = 1440;
  localparam int RESULT_CAP   = 2880;

  // Operation codes carried in the op field.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                op;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } in_word_t;

  typedef struct packed {
    logic [WAIT_W-1:0] minutes_to_next;
    logic              in_interval;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic scan;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic out_full;
  } status_t;

endpackage

// File: src/dsac_datapath.sv
`timescale 1ns / 1ps

module dsac_datapath #(
  parameter int MAX_TIMES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  dsac_pkg::in_word_t  in_word,
  input  dsac_pkg::cmd_t      cmd,
  input  logic                out_ready,
  output dsac_pkg::status_t   status,
  output logic                out_valid,
  output dsac_pkg::out_word_t out_word
);

  localparam int AW = (MAX_TIMES > 1) ? $clog2(MAX_TIMES) : 1;
  localparam int CW = $clog2(MAX_TIMES + 1);
  localparam int TW = dsac_pkg::TIME_W;
  localparam int WW = dsac_pkg::WAIT_W;

  // Time table storage, one entry written or read per cycle.
  logic [TW-1:0] mem [MAX_TIMES];

  logic [CW-1:0] count;
  logic [AW-1:0] addr;
  logic [AW-1:0] last_idx;
  logic          issuing;
  logic          rd_valid;
  logic [AW-1:0] rd_idx;
  logic [TW-1:0] rd_data;
  logic [TW-1:0] now_r;
  logic [TW-1:0] start_r;
  logic [TW-1:0] entry0;
  logic          in_pair;
  logic          found;
  logic [WW-1:0] wait_in;
  logic [WW-1:0] wait_st;
  logic [TW-1:0] in_minutes;
  logic          full;
  logic [CW-1:0] last_wide;
  logic signed [WW:0] wrap_sum;
  dsac_pkg::out_word_t result;

  // Minutes since midnight of the incoming word.
  assign in_minutes = TW'(in_word.hour) * TW'(dsac_pkg::HOUR_MINUTES) + TW'(in_word.minute);
  assign full       = (count == CW'(MAX_TIMES));

  // Last entry read in a scan: the end of the last complete pair, or entry 0.
  always_comb begin
    if (count < CW'(2)) begin
      last_wide = '0;
    end else if (count[0]) begin
      last_wide = count - CW'(2);
    end else begin
      last_wide = count - CW'(1);
    end
  end
  assign last_idx = last_wide[AW-1:0];

  // Table write on load and registered read during the scan.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[AW-1:0]] <= in_minutes;
    end
    if (cmd.scan && issuing) begin
      rd_data <= mem[addr];
      rd_idx  <= addr;
    end
  end

  // Entry count and scan sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      issuing  <= 1'b0;
      rd_valid <= 1'b0;
      addr     <= '0;
    end else begin
      if (cmd.load && !full) begin
        count <= count + CW'(1);
      end
      if (cmd.start) begin
        issuing  <= 1'b1;
        rd_valid <= 1'b0;
        addr     <= '0;
      end else if (cmd.scan) begin
        rd_valid <= issuing;
        if (issuing) begin
          if (addr == last_idx) begin
            issuing <= 1'b0;
          end else begin
            addr <= addr + AW'(1);
          end
        end
      end
    end
  end

  // Pair evaluation as each entry arrives from the table.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      now_r   <= in_minutes;
      in_pair <= 1'b0;
      found   <= 1'b0;
    end else if (cmd.scan && rd_valid) begin
      if (rd_idx == '0) begin
        entry0 <= rd_data;
      end
      if (!rd_idx[0]) begin
        start_r <= rd_data;
      end else begin
        if (!in_pair && now_r >= start_r && now_r < rd_data) begin
          in_pair <= 1'b1;
          wait_in <= WW'(rd_data - now_r);
        end
        if (!found && start_r > now_r) begin
          found   <= 1'b1;
          wait_st <= WW'(start_r - now_r);
        end
      end
    end
  end

  // Next-day wrap to entry 0, clamped to the result range.
  assign wrap_sum = $signed((WW+1)'(dsac_pkg::DAY_MINUTES)) + $signed({2'b00, entry0})
                  - $signed({2'b00, now_r});

  always_comb begin
    result = '0;
    if (count == '0) begin
      result.minutes_to_next = WW'(dsac_pkg::DAY_MINUTES);
    end else if (in_pair) begin
      result.minutes_to_next = wait_in;
      result.in_interval     = 1'b1;
    end else if (found) begin
      result.minutes_to_next = wait_st;
    end else if (wrap_sum[WW]) begin
      result.minutes_to_next = '0;
    end else if (wrap_sum > $signed((WW+1)'(dsac_pkg::RESULT_CAP))) begin
      result.minutes_to_next = WW'(dsac_pkg::RESULT_CAP);
    end else begin
      result.minutes_to_next = wrap_sum[WW-1:0];
    end
  end

  // Output register toward the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word <= result;
    end
  end

  assign status.done     = !issuing && !rd_valid;
  assign status.out_full = out_valid && !out_ready;

endmodule

// File: src/dsac_ctrl.sv
`timescale 1ns / 1ps

module dsac_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_op,
  input  dsac_pkg::status_t  status,
  output logic               in_ready,
  output dsac_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == dsac_pkg::OP_QUERY) begin
            cmd.start  = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/daily_schedule_alarm_calculator.sv
`timescale 1ns / 1ps
// Daily schedule alarm calculator.
// Input channel (in_valid/in_ready/in_word): a word with op = load appends
// hour:minute to the time table; a load into a full table is dropped. A word
// with op = query gives the current hour:minute and yields one output word.
// Output channel (out_valid/out_ready/out_word): minutes to the next alarm
// and whether the current time is inside a start/end pair.
// A query reads N table entries between acceptance and the output register,
// where N is every entry up to the end of the last complete pair, or one when
// fewer than two are stored. The single table read port, one entry per cycle,
// sets the scan length; at most MAX_TIMES entries are read.
// Reset empties the table (count to zero); stored times are not cleared.
// The result sits in an output register: loads and a new query are accepted
// while it waits, but a finished query holds until the receiver takes the
// previous word.
module daily_schedule_alarm_calculator #(
  parameter int MAX_TIMES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsac_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output dsac_pkg::out_word_t out_word
);

  dsac_pkg::cmd_t    cmd;
  dsac_pkg::status_t status;

  dsac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_word.op),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  dsac_datapath #(
    .MAX_TIMES (MAX_TIMES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
